### rtl/led_pixel_color_correct_core_macros.svh
`ifndef LED_PIXEL_COLOR_CORRECT_CORE_MACROS_SVH
`define LED_PIXEL_COLOR_CORRECT_CORE_MACROS_SVH

// checked only while out of reset
`define LPCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on the edge after one that sees reset held
`define LPCC_ASSERT_IN_RESET(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> prop) \
        else $error(msg);

`endif

### rtl/lpcc_pkg.sv
package lpcc_pkg;

    localparam int ChanW = 8;
    localparam int PosW = 10;
    localparam int PctW = 7;
    localparam int EnW = 5;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW = 8;

    localparam int GammaX10Default = 22;
    localparam int GammaWideW = 352;

    localparam int PipeDepth = 14;
    localparam int DivStages = 4;

    localparam int WhiteSpread = 40;
    localparam int BlueFactor = 242;
    localparam int OtherFactor = 255;

    // floor(x / 100) as (x * PctRecip) >> PctShift, exact for x below 43690
    localparam int PctProdW = ChanW + PctW;
    localparam int PctRecipW = 16;
    localparam int PctRecip = 41944;
    localparam int PctShift = 22;
    localparam int CapW = 9;

    localparam logic [EnW-1:0] StageEnablesReset = 5'd31;
    localparam logic WhiteModeReset = 1'b1;
    localparam logic [ChanW-1:0] MaxBrightnessReset = 8'd200;
    localparam logic [ChanW-1:0] WhiteThresholdReset = 8'd150;
    localparam logic [ChanW-1:0] WhiteTargetReset = 8'd100;
    localparam logic [PctW-1:0] GreenPctReset = 7'd28;
    localparam logic [PctW-1:0] BluePctReset = 7'd8;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_STAGE_ENABLES   = 3'd0,
        CFG_WHITE_MODE      = 3'd1,
        CFG_MAX_BRIGHTNESS  = 3'd2,
        CFG_WHITE_THRESHOLD = 3'd3,
        CFG_WHITE_TARGET    = 3'd4,
        CFG_GREEN_PCT       = 3'd5,
        CFG_BLUE_PCT        = 3'd6
    } cfg_index_t;

    typedef enum int {
        EN_CLAMP    = 0,
        EN_BROWN    = 1,
        EN_GAMMA    = 2,
        EN_DITHER   = 3,
        EN_SPECTRAL = 4
    } stage_bit_t;

    // row is position bits [1:0], column is position bits [3:2]
    localparam logic [0:15][3:0] DitherMatrix = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    typedef logic [255:0][ChanW-1:0] gamma_table_t;

    // y = count of k in 1..255 with (2k-1)^10 * 255^g <= 2^10 * 255^10 * i^g
    function automatic gamma_table_t build_gamma(input int gamma_x10);
        logic [GammaWideW-1:0] base;
        logic [GammaWideW-1:0] rhs;
        logic [GammaWideW-1:0] bound;
        int y;
        logic done;
        gamma_table_t tbl;
        base = GammaWideW'(1);
        for (int j = 0; j < gamma_x10; j++)
        begin
            base = base * GammaWideW'(255);
        end
        y = 0;
        for (int i = 0; i < 256; i++)
        begin
            rhs = GammaWideW'(1024);
            for (int j = 0; j < 10; j++)
            begin
                rhs = rhs * GammaWideW'(255);
            end
            for (int j = 0; j < gamma_x10; j++)
            begin
                rhs = rhs * GammaWideW'(i);
            end
            done = 1'b0;
            for (int n = 0; n < 256; n++)
            begin
                if (!done && y < 255)
                begin
                    bound = base;
                    for (int j = 0; j < 10; j++)
                    begin
                        bound = bound * GammaWideW'(2 * (y + 1) - 1);
                    end
                    if (bound <= rhs)
                    begin
                        y = y + 1;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            tbl[i] = ChanW'(y);
        end
        return tbl;
    endfunction

endpackage

### rtl/lpcc_if.sv
interface lpcc_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [lpcc_pkg::ChanW-1:0]   pixel_red;
    logic [lpcc_pkg::ChanW-1:0]   pixel_green;
    logic [lpcc_pkg::ChanW-1:0]   pixel_blue;
    logic [lpcc_pkg::PosW-1:0]    pixel_position;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, pixel_position,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, pixel_position,
        output ready
    );
endinterface

interface lpcc_result_if;
    logic                         valid;
    logic                         ready;
    logic [lpcc_pkg::ChanW-1:0]   out_red;
    logic [lpcc_pkg::ChanW-1:0]   out_green;
    logic [lpcc_pkg::ChanW-1:0]   out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

### rtl/led_pixel_color_correct_core.sv
// pipeline: an accepted word passes the divider, clamp multiply, white detect, white subtract, brown product,
// brown cap, brown apply, gamma, dither and spectral output registers in order to the output
// throughput: one word per cycle; a stall holds only stages that are full, so bubbles close up
// and input is taken while a result waits and a stage is empty
// divider for the brightness clamp is 4 pipelined stages of 2 quotient bits
// reset: async active low, clears all valid bits and loads register defaults; the gamma table is constant
module led_pixel_color_correct_core #(
    parameter int GAMMA_X10 = lpcc_pkg::GammaX10Default
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lpcc_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [lpcc_pkg::CfgDataW-1:0]    cfg_data,
    lpcc_pixel_if.sink                       pixel_in,
    lpcc_result_if.source                    pixel_out
);

    localparam int NumStages = lpcc_pkg::PipeDepth;
    localparam int DivLast = lpcc_pkg::DivStages;
    localparam int StMul = DivLast + 1;
    localparam int StWh = DivLast + 2;
    localparam int StWs = DivLast + 3;
    localparam int StBp = DivLast + 4;
    localparam int StBc = DivLast + 5;
    localparam int StBa = DivLast + 6;
    localparam int StGm = DivLast + 7;
    localparam int StDt = DivLast + 8;
    localparam int StOut = DivLast + 9;
    localparam int CW = lpcc_pkg::ChanW;
    localparam int RecipProdW = lpcc_pkg::PctProdW + lpcc_pkg::PctRecipW;

    localparam lpcc_pkg::gamma_table_t GammaRom = lpcc_pkg::build_gamma(GAMMA_X10);

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
    } rgb_t;

    typedef struct packed {
        rgb_t       c;
        logic [3:0] pos;
    } pix_t;

    typedef struct packed {
        pix_t          px;
        logic          clamp;
        logic [CW-1:0] mx;
        logic [CW-1:0] rem;
        logic [CW-1:0] quo;
    } div_t;

    typedef struct packed {
        pix_t          px;
        logic          white;
        logic [CW-1:0] delta;
    } wht_t;

    typedef struct packed {
        pix_t                          px;
        logic                          brown;
        logic [lpcc_pkg::PctProdW-1:0] prod_g;
        logic [lpcc_pkg::PctProdW-1:0] prod_b;
    } brp_t;

    typedef struct packed {
        pix_t                      px;
        logic                      brown;
        logic [lpcc_pkg::CapW-1:0] cap_g;
        logic [lpcc_pkg::CapW-1:0] cap_b;
    } brc_t;

    function automatic logic [CW-1:0] max3(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                           input logic [CW-1:0] c);
        logic [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [CW-1:0] min3(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                           input logic [CW-1:0] c);
        logic [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [CW:0] div_step(input logic [CW-1:0] rem, input logic [CW-1:0] dv);
        logic [CW:0] t;
        t = {rem, 1'b0};
        if (t >= {1'b0, dv})
        begin
            return {1'b1, CW'(t - {1'b0, dv})};
        end
        return {1'b0, t[CW-1:0]};
    endfunction

    function automatic logic [CW-1:0] sub_floor(input logic [CW-1:0] c, input logic [CW-1:0] d);
        return (c > d) ? (c - d) : '0;
    endfunction

    function automatic logic [CW-1:0] dither_one(input logic [CW-1:0] c, input logic [3:0] t);
        return (c[3:0] > t && c != {CW{1'b1}}) ? (c + CW'(1)) : c;
    endfunction

    function automatic logic [CW-1:0] scale(input logic [CW-1:0] c, input logic [CW-1:0] f);
        logic [2*CW-1:0] p;
        p = c * f;
        return p[2*CW-1:CW];
    endfunction

    // configuration registers
    logic [lpcc_pkg::EnW-1:0] stage_en_reg;
    logic                     white_mode_reg;
    logic [CW-1:0]            max_bright_reg;
    logic [CW-1:0]            white_thr_reg;
    logic [CW-1:0]            white_tgt_reg;
    logic [lpcc_pkg::PctW-1:0] green_pct_reg;
    logic [lpcc_pkg::PctW-1:0] blue_pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_en_reg   <= lpcc_pkg::StageEnablesReset;
            white_mode_reg <= lpcc_pkg::WhiteModeReset;
            max_bright_reg <= lpcc_pkg::MaxBrightnessReset;
            white_thr_reg  <= lpcc_pkg::WhiteThresholdReset;
            white_tgt_reg  <= lpcc_pkg::WhiteTargetReset;
            green_pct_reg  <= lpcc_pkg::GreenPctReset;
            blue_pct_reg   <= lpcc_pkg::BluePctReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpcc_pkg::CFG_STAGE_ENABLES:   stage_en_reg   <= cfg_data[lpcc_pkg::EnW-1:0];
                lpcc_pkg::CFG_WHITE_MODE:      white_mode_reg <= cfg_data[0];
                lpcc_pkg::CFG_MAX_BRIGHTNESS:  max_bright_reg <= cfg_data[CW-1:0];
                lpcc_pkg::CFG_WHITE_THRESHOLD: white_thr_reg  <= cfg_data[CW-1:0];
                lpcc_pkg::CFG_WHITE_TARGET:    white_tgt_reg  <= cfg_data[CW-1:0];
                lpcc_pkg::CFG_GREEN_PCT:       green_pct_reg  <= cfg_data[lpcc_pkg::PctW-1:0];
                lpcc_pkg::CFG_BLUE_PCT:        blue_pct_reg   <= cfg_data[lpcc_pkg::PctW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages-1:0] go;

    always_comb
    begin
        go[NumStages-1] = !valid_reg[NumStages-1] || pixel_out.ready;
        for (int i = NumStages - 2; i >= 0; i--)
        begin
            go[i] = !valid_reg[i] || go[i+1];
        end
        valid_next = {valid_reg[NumStages-2:0], pixel_in.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (go & valid_next) | (~go & valid_reg);
        end
    end

    assign pixel_in.ready = go[0];

    // stage payloads
    div_t div_reg  [0:DivLast];
    div_t div_next [0:DivLast];
    pix_t mul_reg, mul_next;
    wht_t wh_reg, wh_next;
    pix_t ws_reg, ws_next;
    brp_t bp_reg, bp_next;
    brc_t bc_reg, bc_next;
    pix_t ba_reg, ba_next;
    pix_t gm_reg, gm_next;
    rgb_t dt_reg, dt_next;
    rgb_t out_reg, out_next;

    // capture and brightness divider
    always_comb
    begin
        logic [CW-1:0] mx;
        logic [CW:0]   step_a;
        logic [CW:0]   step_b;
        mx = max3(pixel_in.pixel_red, pixel_in.pixel_green, pixel_in.pixel_blue);
        div_next[0].px.c.r = pixel_in.pixel_red;
        div_next[0].px.c.g = pixel_in.pixel_green;
        div_next[0].px.c.b = pixel_in.pixel_blue;
        div_next[0].px.pos = pixel_in.pixel_position[3:0];
        div_next[0].clamp  = stage_en_reg[lpcc_pkg::EN_CLAMP]
                             && (max_bright_reg != {CW{1'b1}}) && (mx > max_bright_reg);
        div_next[0].mx     = mx;
        div_next[0].rem    = max_bright_reg;
        div_next[0].quo    = '0;
        for (int k = 1; k <= DivLast; k++)
        begin
            step_a = div_step(div_reg[k-1].rem, div_reg[k-1].mx);
            step_b = div_step(step_a[CW-1:0], div_reg[k-1].mx);
            div_next[k]     = div_reg[k-1];
            div_next[k].rem = step_b[CW-1:0];
            div_next[k].quo = {div_reg[k-1].quo[CW-3:0], step_a[CW], step_b[CW]};
        end
    end

    // clamp multiply, white detection and white subtraction
    always_comb
    begin
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        mul_next.pos = div_reg[DivLast].px.pos;
        mul_next.c   = div_reg[DivLast].px.c;
        if (div_reg[DivLast].clamp)
        begin
            mul_next.c.r = scale(div_reg[DivLast].px.c.r, div_reg[DivLast].quo);
            mul_next.c.g = scale(div_reg[DivLast].px.c.g, div_reg[DivLast].quo);
            mul_next.c.b = scale(div_reg[DivLast].px.c.b, div_reg[DivLast].quo);
        end

        mx = max3(mul_reg.c.r, mul_reg.c.g, mul_reg.c.b);
        mn = min3(mul_reg.c.r, mul_reg.c.g, mul_reg.c.b);
        wh_next.px    = mul_reg;
        wh_next.white = white_mode_reg && (mn > white_thr_reg)
                        && ((mx - mn) < CW'(lpcc_pkg::WhiteSpread)) && (mn > white_tgt_reg);
        wh_next.delta = mn - white_tgt_reg;

        ws_next = wh_reg.px;
        if (wh_reg.white)
        begin
            ws_next.c.r = sub_floor(wh_reg.px.c.r, wh_reg.delta);
            ws_next.c.g = sub_floor(wh_reg.px.c.g, wh_reg.delta);
            ws_next.c.b = sub_floor(wh_reg.px.c.b, wh_reg.delta);
        end
    end

    // brown clamp
    always_comb
    begin
        logic [RecipProdW-1:0] cg;
        logic [RecipProdW-1:0] cb;
        bp_next.px     = ws_reg;
        bp_next.brown  = stage_en_reg[lpcc_pkg::EN_BROWN]
                         && (ws_reg.c.r > ws_reg.c.g) && (ws_reg.c.g >= ws_reg.c.b);
        bp_next.prod_g = ws_reg.c.r * green_pct_reg;
        bp_next.prod_b = ws_reg.c.r * blue_pct_reg;

        cg = bp_reg.prod_g * lpcc_pkg::PctRecipW'(lpcc_pkg::PctRecip);
        cb = bp_reg.prod_b * lpcc_pkg::PctRecipW'(lpcc_pkg::PctRecip);
        bc_next.px    = bp_reg.px;
        bc_next.brown = bp_reg.brown;
        bc_next.cap_g = cg[lpcc_pkg::PctShift +: lpcc_pkg::CapW];
        bc_next.cap_b = cb[lpcc_pkg::PctShift +: lpcc_pkg::CapW];

        ba_next = bc_reg.px;
        if (bc_reg.brown)
        begin
            if ({1'b0, bc_reg.px.c.g} > bc_reg.cap_g)
            begin
                ba_next.c.g = bc_reg.cap_g[CW-1:0];
            end
            if ({1'b0, bc_reg.px.c.b} > bc_reg.cap_b)
            begin
                ba_next.c.b = bc_reg.cap_b[CW-1:0];
            end
        end
    end

    // gamma, dither, spectral scaling
    always_comb
    begin
        logic [3:0] thr;
        gm_next = ba_reg;
        if (stage_en_reg[lpcc_pkg::EN_GAMMA])
        begin
            gm_next.c.r = GammaRom[ba_reg.c.r];
            gm_next.c.g = GammaRom[ba_reg.c.g];
            gm_next.c.b = GammaRom[ba_reg.c.b];
        end

        thr = lpcc_pkg::DitherMatrix[{gm_reg.pos[1:0], gm_reg.pos[3:2]}];
        dt_next = gm_reg.c;
        if (stage_en_reg[lpcc_pkg::EN_DITHER])
        begin
            dt_next.r = dither_one(gm_reg.c.r, thr);
            dt_next.g = dither_one(gm_reg.c.g, thr);
            dt_next.b = dither_one(gm_reg.c.b, thr);
        end

        out_next = dt_reg;
        if (stage_en_reg[lpcc_pkg::EN_SPECTRAL])
        begin
            out_next.r = scale(dt_reg.r, CW'(lpcc_pkg::OtherFactor));
            out_next.g = scale(dt_reg.g, CW'(lpcc_pkg::OtherFactor));
            out_next.b = scale(dt_reg.b, CW'(lpcc_pkg::BlueFactor));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DivLast; k++)
        begin
            if (go[k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
        if (go[StMul])
        begin
            mul_reg <= mul_next;
        end
        if (go[StWh])
        begin
            wh_reg <= wh_next;
        end
        if (go[StWs])
        begin
            ws_reg <= ws_next;
        end
        if (go[StBp])
        begin
            bp_reg <= bp_next;
        end
        if (go[StBc])
        begin
            bc_reg <= bc_next;
        end
        if (go[StBa])
        begin
            ba_reg <= ba_next;
        end
        if (go[StGm])
        begin
            gm_reg <= gm_next;
        end
        if (go[StDt])
        begin
            dt_reg <= dt_next;
        end
        if (go[StOut])
        begin
            out_reg <= out_next;
        end
    end

    assign pixel_out.valid     = valid_reg[NumStages-1];
    assign pixel_out.out_red   = out_reg.r;
    assign pixel_out.out_green = out_reg.g;
    assign pixel_out.out_blue  = out_reg.b;

endmodule

### rtl/lpcc_checker.sv
`include "led_pixel_color_correct_core_macros.svh"

module lpcc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lpcc_pkg::ChanW-1:0]  out_red,
    input logic [lpcc_pkg::ChanW-1:0]  out_green,
    input logic [lpcc_pkg::ChanW-1:0]  out_blue
);

    localparam int CountW = $clog2(lpcc_pkg::PipeDepth + 1) + 1;

    // words taken in and not yet delivered
    logic [CountW-1:0] outstanding_reg;
    logic [CountW-1:0] outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            outstanding_next = outstanding_reg + CountW'(1);
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            outstanding_next = outstanding_reg - CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `LPCC_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled word changed")
    `LPCC_ASSERT(a_no_extra_word, clk, rst_n, out_valid |-> outstanding_reg != '0, "word with no input")
    `LPCC_ASSERT(a_depth_bound, clk, rst_n, outstanding_reg <= CountW'(lpcc_pkg::PipeDepth), "more words in flight than stages")
    `LPCC_ASSERT(a_ready_when_drained, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")
    `LPCC_ASSERT_IN_RESET(a_quiet_in_reset, clk, rst_n, !out_valid, "output valid during reset")

endmodule

bind led_pixel_color_correct_core lpcc_checker u_lpcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .out_red   (pixel_out.out_red),
    .out_green (pixel_out.out_green),
    .out_blue  (pixel_out.out_blue)
);
